### hw/rtl/qmix_pkg.sv
// Shared types, constants and table functions for the quadrature mixer block.
// Depends on nothing; every other RTL file of the block uses it.
`default_nettype none

package qmix_pkg;

   localparam int SINE_TABLE_ADDRESS_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF             = 16;

   localparam int PHASE_BITS       = 32;
   localparam int COEF_BITS        = 16;
   localparam int FILTER_FRAC_BITS = 16;
   localparam int ACC_BITS         = 40;
   localparam int ACC_LO_BITS      = 24;
   localparam int MUL_BITS         = 25;
   localparam int PROD_BITS        = 2 * MUL_BITS;
   localparam int SUM_BITS         = 58;
   localparam int WIDE_BITS        = SUM_BITS - FILTER_FRAC_BITS;
   localparam int OUT_BITS         = 24;
   localparam int ROM_BITS         = 23;
   localparam int CSR_INDEX_BITS   = 8;
   localparam int CSR_DATA_BITS    = 32;

   localparam logic [PHASE_BITS-1:0] TUNING_WORD_RESET = 32'd486957743;
   localparam logic [COEF_BITS-1:0]  FILTER_COEF_RESET = 16'd64881;

   // Register indexes on the control port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TUNING_WORD = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_COEF = 8'd1;

   // Odd Taylor coefficients of sin(pi*x/2), Q30
   localparam longint POLY_C1 = 64'sd1686629713;
   localparam longint POLY_C3 = -64'sd693598668;
   localparam longint POLY_C5 = 64'sd85569306;
   localparam longint POLY_C7 = -64'sd5026995;
   localparam longint POLY_C9 = 64'sd172272;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_SIN,
      ST_MUL_COS,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_FINISH
   } qmix_state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_MUL_SIN,
      OP_MUL_COS,
      OP_MUL_LO,
      OP_MUL_HI
   } dp_op_type;

   typedef struct packed {
      logic      load;
      logic      rd_cos;
      dp_op_type op;
      logic      commit;
      logic      emit_zero;
   } dp_cmd_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] tuning_word;
      logic [COEF_BITS-1:0]  filter_coef;
   } cfg_type;

   // Q30 product, rounded half up
   function automatic longint q30_mul(input longint a, input longint b);
      longint p;
      p = a * b + (longint'(1) <<< 29);
      return p >>> 30;
   endfunction

   // Quarter-wave sine entry k, evaluated at elaboration
   function automatic logic [ROM_BITS-1:0] quarter_sine(input int k, input int addr_bits,
                                                       input int sample_bits);
      longint amp;
      longint x;
      longint x2;
      longint t;
      longint s;
      amp = (longint'(1) <<< (sample_bits - 1)) - 1;
      x   = longint'(2 * k + 1) <<< (29 - addr_bits);
      x2  = q30_mul(x, x);
      t   = POLY_C9;
      t   = POLY_C7 + q30_mul(t, x2);
      t   = POLY_C5 + q30_mul(t, x2);
      t   = POLY_C3 + q30_mul(t, x2);
      t   = POLY_C1 + q30_mul(t, x2);
      s   = q30_mul(t, x);
      s   = (s * amp + (longint'(1) <<< 29)) >>> 30;
      if (s < 0) s = 0;
      if (s > amp) s = amp;
      return ROM_BITS'(s);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/qmix_if.sv
// Channel interfaces of the quadrature mixer: sample input, result output, control writes.
// Depends on qmix_pkg for widths.
`default_nettype none

interface qmix_req_if #(
   parameter int SAMPLE_BITS = qmix_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;
   logic                          silent;

   modport source (output valid, sample_i, sample_q, silent, input ready);
   modport sink   (input valid, sample_i, sample_q, silent, output ready);
endinterface

interface qmix_rsp_if ();
   logic                                  valid;
   logic                                  ready;
   logic signed [qmix_pkg::OUT_BITS-1:0]  filtered_out;

   modport source (output valid, filtered_out, input ready);
   modport sink   (input valid, filtered_out, output ready);
endinterface

interface qmix_csr_if ();
   logic                                 valid;
   logic                                 ready;
   logic [qmix_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [qmix_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/qmix_csr.sv
// Control registers of the quadrature mixer: NCO tuning word and filter leak factor.
// Depends on qmix_pkg and qmix_csr_if.
`default_nettype none

module qmix_csr (
   input  logic              clock,
   input  logic              reset,
   qmix_csr_if.sink          csr_chan,
   output qmix_pkg::cfg_type cfg
);
   import qmix_pkg::*;

   logic [PHASE_BITS-1:0] tuning_word_ff, tuning_word_in;
   logic [COEF_BITS-1:0]  filter_coef_ff, filter_coef_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      tuning_word_in = tuning_word_ff;
      filter_coef_in = filter_coef_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TUNING_WORD: tuning_word_in = csr_chan.data[PHASE_BITS-1:0];
            CSR_FILTER_COEF: filter_coef_in = csr_chan.data[COEF_BITS-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_word_ff <= TUNING_WORD_RESET;
         filter_coef_ff <= FILTER_COEF_RESET;
      end else begin
         tuning_word_ff <= tuning_word_in;
         filter_coef_ff <= filter_coef_in;
      end
   end

   assign cfg.tuning_word = tuning_word_ff;
   assign cfg.filter_coef = filter_coef_ff;

endmodule

`default_nettype wire

### hw/rtl/qmix_dp.sv
// Datapath: phase accumulator, quarter-wave sine ROM, one shared multiplier,
// mixer sum, leaky-integrator accumulator and output register. Depends on qmix_pkg.
`default_nettype none

module qmix_dp #(
   parameter int SINE_TABLE_ADDRESS_BITS = qmix_pkg::SINE_TABLE_ADDRESS_BITS_DEF,
   parameter int SAMPLE_BITS             = qmix_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qmix_pkg::dp_cmd_type                 cmd,
   input  qmix_pkg::cfg_type                    cfg,
   input  logic signed [SAMPLE_BITS-1:0]        sample_i,
   input  logic signed [SAMPLE_BITS-1:0]        sample_q,
   output logic signed [qmix_pkg::OUT_BITS-1:0] filtered_out
);
   import qmix_pkg::*;

   localparam int TBL_SIZE = 1 << SINE_TABLE_ADDRESS_BITS;
   localparam int MAG_BITS = SAMPLE_BITS - 1;
   localparam int MIX_BITS = 2 * SAMPLE_BITS + 2;
   localparam int X_BITS   = MIX_BITS - (SAMPLE_BITS - 1);

   localparam logic signed [MIX_BITS-1:0] MIX_RND =
      MIX_BITS'(longint'(1) <<< (SAMPLE_BITS - 2));
   localparam logic signed [SUM_BITS-1:0] FILT_RND =
      SUM_BITS'(longint'(1) <<< (FILTER_FRAC_BITS - 1));
   localparam logic signed [WIDE_BITS-1:0] ACC_MAX_W =
      WIDE_BITS'((longint'(1) <<< (ACC_BITS - 1)) - 1);
   localparam logic signed [WIDE_BITS-1:0] ACC_MIN_W =
      WIDE_BITS'(-(longint'(1) <<< (ACC_BITS - 1)));
   localparam logic signed [WIDE_BITS-1:0] OUT_MAX_W =
      WIDE_BITS'((longint'(1) <<< (OUT_BITS - 1)) - 1);
   localparam logic signed [WIDE_BITS-1:0] OUT_MIN_W =
      WIDE_BITS'(-(longint'(1) <<< (OUT_BITS - 1)));

   // Constant quarter-wave table, read through a registered port
   logic [MAG_BITS-1:0] sine_rom [TBL_SIZE];

   for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
      assign sine_rom[k] = MAG_BITS'(quarter_sine(k, SINE_TABLE_ADDRESS_BITS, SAMPLE_BITS));
   end

   logic [PHASE_BITS-1:0]                phase_ff, phase_in;
   logic signed [ACC_BITS-1:0]           acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0]        samp_i_ff, samp_q_ff;
   logic [MAG_BITS-1:0]                  rom_q_ff;
   logic signed [PROD_BITS-1:0]          prod_ff, prod_in;
   logic signed [MIX_BITS-1:0]           mix_ff, mix_in;
   logic signed [SUM_BITS-1:0]           part_ff, part_in;
   logic signed [OUT_BITS-1:0]           out_ff, out_in;

   logic [1:0]                           quad;
   logic [SINE_TABLE_ADDRESS_BITS-1:0]   idx_raw, sin_idx, cos_idx, rom_addr;
   logic                                 sin_neg, cos_neg;
   logic signed [MUL_BITS-1:0]           mul_a, mul_b;
   logic signed [MIX_BITS-1:0]           p_mix;
   logic signed [X_BITS-1:0]             x_val;
   logic signed [SUM_BITS-1:0]           total;
   logic signed [WIDE_BITS-1:0]          wide;
   logic signed [ACC_BITS-1:0]           acc_sat;
   logic signed [OUT_BITS-1:0]           out_sat;

   // Quadrant decode; cosine is the phase one quadrant ahead
   assign quad     = phase_ff[PHASE_BITS-1 -: 2];
   assign idx_raw  = phase_ff[PHASE_BITS-3 -: SINE_TABLE_ADDRESS_BITS];
   assign sin_idx  = quad[0] ? ~idx_raw : idx_raw;
   assign cos_idx  = quad[0] ? idx_raw : ~idx_raw;
   assign sin_neg  = quad[1];
   assign cos_neg  = quad[1] ^ quad[0];
   assign rom_addr = cmd.rd_cos ? cos_idx : sin_idx;

   // Shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         OP_MUL_SIN: begin
            mul_a = MUL_BITS'(samp_i_ff);
            mul_b = MUL_BITS'(rom_q_ff);
         end
         OP_MUL_COS: begin
            mul_a = MUL_BITS'(samp_q_ff);
            mul_b = MUL_BITS'(rom_q_ff);
         end
         OP_MUL_LO: begin
            mul_a = MUL_BITS'(acc_ff[ACC_LO_BITS-1:0]);
            mul_b = MUL_BITS'(cfg.filter_coef);
         end
         OP_MUL_HI: begin
            mul_a = MUL_BITS'($signed(acc_ff[ACC_BITS-1:ACC_LO_BITS]));
            mul_b = MUL_BITS'(cfg.filter_coef);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign p_mix = $signed(prod_ff[MIX_BITS-1:0]);
   assign x_val = $signed(mix_ff[MIX_BITS-1:SAMPLE_BITS-1]);

   always_comb begin
      prod_in = prod_ff;
      mix_in  = mix_ff;
      part_in = part_ff;
      unique case (cmd.op)
         OP_MUL_SIN: prod_in = mul_a * mul_b;
         OP_MUL_COS: begin
            prod_in = mul_a * mul_b;
            mix_in  = MIX_RND + (sin_neg ? -p_mix : p_mix);
         end
         OP_MUL_LO: begin
            prod_in = mul_a * mul_b;
            mix_in  = mix_ff + (cos_neg ? p_mix : -p_mix);
         end
         OP_MUL_HI: begin
            prod_in = mul_a * mul_b;
            // low product plus rounding plus mixer term at the filter's scale
            part_in = SUM_BITS'(prod_ff) + FILT_RND + (SUM_BITS'(x_val) <<< FILTER_FRAC_BITS);
         end
         default: ;
      endcase
   end

   // Filter update and both saturations
   assign total = (SUM_BITS'(prod_ff) <<< ACC_LO_BITS) + part_ff;
   assign wide  = $signed(total[SUM_BITS-1:FILTER_FRAC_BITS]);

   always_comb begin
      priority if (wide > ACC_MAX_W) acc_sat = ACC_BITS'(ACC_MAX_W);
      else if (wide < ACC_MIN_W)     acc_sat = ACC_BITS'(ACC_MIN_W);
      else                           acc_sat = ACC_BITS'(wide);
      priority if (wide > OUT_MAX_W) out_sat = OUT_BITS'(OUT_MAX_W);
      else if (wide < OUT_MIN_W)     out_sat = OUT_BITS'(OUT_MIN_W);
      else                           out_sat = OUT_BITS'(wide);
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      out_in   = out_ff;
      if (cmd.commit) begin
         phase_in = phase_ff + cfg.tuning_word;
         acc_in   = acc_sat;
         out_in   = out_sat;
      end else if (cmd.emit_zero) begin
         out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_i_ff <= sample_i;
         samp_q_ff <= sample_q;
      end
      rom_q_ff <= sine_rom[rom_addr];
      prod_ff  <= prod_in;
      mix_ff   <= mix_in;
      part_ff  <= part_in;
      out_ff   <= out_in;
   end

   assign filtered_out = out_ff;

endmodule

`default_nettype wire

### hw/rtl/qmix_ctrl.sv
// Controller of the quadrature mixer: sequences the shared multiplier and owns
// the handshakes and result valid flag. Depends on qmix_pkg.
`default_nettype none

module qmix_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_silent,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output qmix_pkg::dp_cmd_type cmd
);
   import qmix_pkg::*;

   qmix_state_type state_ff, state_in;
   logic           silent_ff, silent_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           emit_ok;

   // Output slot is free or is being emptied this cycle
   assign emit_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = req_silent ? ST_FINISH : ST_MUL_SIN;
         end
         ST_MUL_SIN: state_in = ST_MUL_COS;
         ST_MUL_COS: state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (emit_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.op        = OP_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL_SIN: begin
            cmd.op     = OP_MUL_SIN;
            cmd.rd_cos = 1'b1;
         end
         ST_MUL_COS: cmd.op = OP_MUL_COS;
         ST_MUL_LO:  cmd.op = OP_MUL_LO;
         ST_MUL_HI:  cmd.op = OP_MUL_HI;
         ST_FINISH: begin
            cmd.commit    = emit_ok && !silent_ff;
            cmd.emit_zero = emit_ok && silent_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      silent_in = silent_ff;
      if (state_ff == ST_IDLE && req_valid) silent_in = req_silent;
      priority if (state_ff == ST_FINISH && emit_ok) rsp_valid_in = 1'b1;
      else if (rsp_ready)                            rsp_valid_in = 1'b0;
      else                                           rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         silent_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_work_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && !req_silent) |=> (state_ff == ST_MUL_SIN))
      else $error("non-silent transaction did not start the multiply sequence");

   a_silent_skips: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_silent) |=> (state_ff == ST_FINISH && silent_ff))
      else $error("silent transaction did not go straight to finish");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("finish left while the output slot was still full");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside finish");

   a_write_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.emit_zero) |=> rsp_valid_ff)
      else $error("output register written without result valid");
`endif

endmodule

`default_nettype wire

### hw/rtl/quadrature_mixer_with_iir_lowpass.sv
// Top level of the quadrature mixer with leaky-integrator low-pass.
// Depends on qmix_pkg, qmix_if, qmix_csr, qmix_ctrl and qmix_dp.
//
//   channel    dir   handshake       payload
//   req_chan   in    valid/ready     sample_i, sample_q (signed), silent
//   rsp_chan   out   valid/ready     filtered_out (signed 24 bits, Q9.15)
//   csr_chan   in    valid/ready     index (0 tuning word, 1 leak factor), data
//
// Sequence: a normal transaction runs from the accept step through four multiply
//   steps on the single shared multiplier (I*sin, Q*cos, two halves of acc*A) to
//   finish, with the registered sine ROM read in the accept step and the filter
//   sum in finish; a silent one goes from accept straight to finish.
// Reset: synchronous, clears phase and filter accumulator and sets the controller and
//   control registers to their defaults at once; there is no clearing pass.
// Stalls: a finished result waits in the output register; a new transaction is
//   taken meanwhile and holds in its last step until the slot frees.
`default_nettype none

module quadrature_mixer_with_iir_lowpass #(
   parameter int SINE_TABLE_ADDRESS_BITS = qmix_pkg::SINE_TABLE_ADDRESS_BITS_DEF,
   parameter int SAMPLE_BITS             = qmix_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   qmix_req_if.sink    req_chan,
   qmix_rsp_if.source  rsp_chan,
   qmix_csr_if.sink    csr_chan
);
   import qmix_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   logic       req_ready;
   logic       rsp_valid;
   logic signed [OUT_BITS-1:0] filtered_out;

   // Control registers; the user must write only while no transaction is in flight, the block does not enforce it
   qmix_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Sequencer: accept, four multiply steps (skipped for silent samples), then finish into the output slot
   qmix_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_silent (req_chan.silent),
      .req_ready  (req_ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // NCO, mixer and filter arithmetic
   qmix_dp #(
      .SINE_TABLE_ADDRESS_BITS (SINE_TABLE_ADDRESS_BITS),
      .SAMPLE_BITS             (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg),
      .sample_i     (req_chan.sample_i),
      .sample_q     (req_chan.sample_q),
      .filtered_out (filtered_out)
   );

   // Drive the channel ports
   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.filtered_out = filtered_out;

endmodule

`default_nettype wire
